[hw/rtl/mf3_pkg.sv]
// shared types, constants and the ranking pass of the 3x3 red-rank median filter
`timescale 1ns / 1ps

package mf3_pkg;

  // frame geometry limits
  localparam int MAX_WIDTH    = 2048;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MIN_DIM      = 3;

  // window layout: nine slots, row-major, oldest column first
  localparam int WIN_SIZE = 9;
  localparam int WIN_MID  = 4;

  // field and counter widths
  localparam int PIX_W      = 24;
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(HEIGHT_LIMIT);
  localparam int LS_AW      = COL_W + 1;

  // register reset values
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one ranking pass per stage; passes past the middle slot never touch it
  localparam int RANK_STAGES = WIN_MID + 1;

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN_SIZE-1:0] win_t;

  // one window waiting for ranking
  typedef struct packed {
    win_t win;
    logic last;
  } job_t;

  // exchange pass k: slot k against every later slot, swap on strictly greater red
  function automatic win_t rank_pass(win_t w, int unsigned k);
    win_t r;
    pix_t t;
    r = w;
    for (int unsigned l = 1; l < WIN_SIZE; l++) begin
      if ((l > k) && (r[k][23:16] > r[l][23:16])) begin
        t    = r[k];
        r[k] = r[l];
        r[l] = t;
      end
    end
    return r;
  endfunction

endpackage

[hw/rtl/mf3_front.sv]
// front part: raster counters, line memory, window and hand-off of interior windows
`timescale 1ns / 1ps

module mf3_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  mf3_pkg::cfg_reg_e             cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mf3_pkg::pix_t                 in_pix_i,
  output logic                          q_push_o,
  output mf3_pkg::job_t                 q_job_o,
  input  logic                          q_full_i
);
  import mf3_pkg::*;

  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [COL_W-1:0]    col_q, col_d, col_last, col_eff;
  logic [ROW_W-1:0]    row_q, row_d, row_last, row_eff;
  logic                last_col, last_row, bank;
  logic [LS_AW-1:0]    cur_addr, oth_addr;

  logic                accept, a_adv;
  logic                a_valid_q, a_valid_d;
  pix_t                a_pix_q;
  logic                a_emit_q, a_last_q;

  pix_t                line_mem_q [2*MAX_WIDTH];
  pix_t                above2_q, above1_q;
  win_t                win_q, win_next;

  // configuration registers
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WIDTH:  width_d  = cfg_data_i[WIDTH_W-1:0];
        CFG_HEIGHT: height_d = cfg_data_i[HEIGHT_W-1:0];
        default:    width_d  = width_q;
      endcase
    end
  end

  // clamp geometry into its legal range
  always_comb begin
    if (32'(width_q) > 32'(MAX_WIDTH)) begin
      col_last = COL_W'(MAX_WIDTH - 1);
    end else if (width_q < WIDTH_W'(MIN_DIM)) begin
      col_last = COL_W'(MIN_DIM - 1);
    end else begin
      col_last = COL_W'(width_q - WIDTH_W'(1));
    end
    if (height_q > HEIGHT_W'(HEIGHT_LIMIT)) begin
      row_last = ROW_W'(HEIGHT_LIMIT - 1);
    end else if (height_q < HEIGHT_W'(MIN_DIM)) begin
      row_last = ROW_W'(MIN_DIM - 1);
    end else begin
      row_last = ROW_W'(height_q - HEIGHT_W'(1));
    end
  end

  // raster position, wrapped at the last index
  always_comb begin
    last_col = (col_q >= col_last);
    last_row = (row_q >= row_last);
    col_eff  = last_col ? col_last : col_q;
    row_eff  = last_row ? row_last : row_q;
    bank     = row_eff[0];
    cur_addr = {bank, col_eff};
    oth_addr = {~bank, col_eff};
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_eff + ROW_W'(1);
    end else begin
      col_d = col_eff + COL_W'(1);
      row_d = row_eff;
    end
  end

  // handshake: the held item leaves once the queue can take it, or at once if it is a border item
  assign a_adv      = a_valid_q && (!a_emit_q || !q_full_i);
  assign in_ready_o = !a_valid_q || a_adv;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (accept) begin
      a_valid_d = 1'b1;
    end else if (a_adv) begin
      a_valid_d = 1'b0;
    end
  end

  // window after shifting in the held item's column
  always_comb begin
    win_next[0] = win_q[1];
    win_next[1] = win_q[2];
    win_next[2] = above2_q;
    win_next[3] = win_q[4];
    win_next[4] = win_q[5];
    win_next[5] = above1_q;
    win_next[6] = win_q[7];
    win_next[7] = win_q[8];
    win_next[8] = a_pix_q;
  end

  assign q_push_o     = a_adv && a_emit_q;
  assign q_job_o.win  = win_next;
  assign q_job_o.last = a_last_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= WIDTH_RESET;
      height_q  <= HEIGHT_RESET;
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      win_q     <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      a_valid_q <= a_valid_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (a_adv) begin
        win_q <= win_next;
      end
    end
  end

  // held item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q  <= in_pix_i;
      a_emit_q <= (row_eff >= ROW_W'(2)) && (col_eff >= COL_W'(2));
      a_last_q <= last_row && last_col;
    end
  end

  // line memory: two rows by parity, read-before-write at the current column
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem_q[cur_addr] <= in_pix_i;
      above2_q             <= line_mem_q[cur_addr];
      above1_q             <= line_mem_q[oth_addr];
    end
  end

endmodule

[hw/rtl/mf3_queue.sv]
// short window queue between the front and the ranking pipeline
`timescale 1ns / 1ps

module mf3_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mf3_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mf3_pkg::job_t pop_job_o
);
  import mf3_pkg::*;

  job_t                entry_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign full_o    = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_job_o = entry_q[rd_ptr_q];

  // pointer and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QUEUE_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QUEUE_AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QUEUE_AW + 1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

[hw/rtl/mf3_rank.sv]
// back part: five exchange passes, one per stage, ending in the output register
`timescale 1ns / 1ps

module mf3_rank (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mf3_pkg::job_t q_job_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mf3_pkg::pix_t out_pix_o,
  output logic          out_last_o
);
  import mf3_pkg::*;

  win_t                   st_win_q [RANK_STAGES];
  logic [RANK_STAGES-1:0] st_last_q;
  logic [RANK_STAGES-1:0] st_vld_q;
  logic [RANK_STAGES:0]   rdy;
  win_t                   src_win  [RANK_STAGES];
  win_t                   pass_win [RANK_STAGES];
  logic [RANK_STAGES-1:0] src_last;
  logic [RANK_STAGES-1:0] src_vld;

  // stall chain from the output back to the queue
  always_comb begin
    rdy[RANK_STAGES] = out_ready_i;
    for (int s = RANK_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !st_vld_q[s] || rdy[s+1];
    end
  end

  assign q_pop_o = rdy[0] && q_valid_i;

  // stage inputs and the pass each stage performs
  always_comb begin
    src_win[0]  = q_job_i.win;
    src_last[0] = q_job_i.last;
    src_vld[0]  = q_valid_i;
    for (int s = 1; s < RANK_STAGES; s++) begin
      src_win[s]  = st_win_q[s-1];
      src_last[s] = st_last_q[s-1];
      src_vld[s]  = st_vld_q[s-1];
    end
    for (int s = 0; s < RANK_STAGES; s++) begin
      pass_win[s] = rank_pass(src_win[s], s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= '0;
    end else begin
      for (int s = 0; s < RANK_STAGES; s++) begin
        if (rdy[s]) begin
          st_vld_q[s] <= src_vld[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < RANK_STAGES; s++) begin
      if (rdy[s] && src_vld[s]) begin
        st_win_q[s]  <= pass_win[s];
        st_last_q[s] <= src_last[s];
      end
    end
  end

  // the middle slot of the last stage is the result
  assign out_valid_o = st_vld_q[RANK_STAGES-1];
  assign out_pix_o   = st_win_q[RANK_STAGES-1][WIN_MID];
  assign out_last_o  = st_last_q[RANK_STAGES-1];

endmodule

[hw/rtl/median_filter_3x3_red_rank.sv]
// Takes one BGR pixel per clock in raster order, unless in_ready_o is low, and
// returns, for each interior position, the whole pixel of the 3x3 window whose
// red value ranks in the middle under a fixed exchange order; border positions
// produce no item, and last_pixel_o marks the final interior pixel of the frame.
// The sustained rate is one pixel per clock while the output does not stall, set
// by the line memory, which takes one write and two reads per cycle. A pixel
// passes through the input register, where the shifted window is formed, the
// four-entry queue and the first four ranking stages; the fifth stage is the
// output register, and a stall of the queue or the output holds a result back.
// The line memory is not cleared after reset; the first two rows of each frame
// fill it before any of it is used. The user writes width and height through
// the configuration port between frames; the block does not enforce this.
`timescale 1ns / 1ps

module median_filter_3x3_red_rank (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  mf3_pkg::cfg_reg_e              cfg_index_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     in_blue_i,
  input  logic [7:0]                     in_green_i,
  input  logic [7:0]                     in_red_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_blue_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_red_o,
  output logic                           last_pixel_o
);
  import mf3_pkg::*;

  pix_t in_pix, out_pix;
  job_t push_job, pop_job;
  logic q_push, q_full, q_pop, q_valid;

  assign cfg_ready_o = 1'b1;
  assign in_pix      = {in_red_i, in_green_i, in_blue_i};

  // front: counters, line memory and window
  mf3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_pix_i    (in_pix),
    .q_push_o    (q_push),
    .q_job_o     (push_job),
    .q_full_i    (q_full)
  );

  // queue of interior windows
  mf3_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_job_o  (pop_job)
  );

  // back: ranking pipeline and output register
  mf3_rank u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pix_o   (out_pix),
    .out_last_o  (last_pixel_o)
  );

  assign out_red_o   = out_pix[23:16];
  assign out_green_o = out_pix[15:8];
  assign out_blue_o  = out_pix[7:0];

`ifndef SYNTHESIS
  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("window pushed into full queue");

  // the back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> q_valid)
    else $error("window popped from empty queue");

  // a waiting window is not lost without a pop
  assert property (@(posedge clk_i) disable iff (!rst_ni) (q_valid && !q_pop) |=> q_valid)
    else $error("queued window dropped");
`endif

endmodule
